FILE: rtl/lfhr_pkg.sv
// Package for the LED fire heat renderer: transaction payload structs,
// action codes, controller/datapath command and status structs, fire colour table.
// No dependencies.
package lfhr_pkg;

  localparam logic [1:0] ACT_DECAY  = 2'd0;
  localparam logic [1:0] ACT_INJECT = 2'd1;
  localparam logic [1:0] ACT_RENDER = 2'd2;

  localparam int FIRE_LEN = 12;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] column;
    logic [4:0] power;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pixel_row;
    logic [4:0] pixel_column;
    logic [7:0] colour;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic load_dec;
    logic load_inj;
    logic load_rnd;
    logic step;
    logic side;
    logic wr_dec;
    logic wr_inj;
    logic heat_ld;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic p_le2;
    logic d_zero;
    logic ptr_last;
    logic y_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] fire_colour(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'd0;
      4'd1:    c = 8'd2;
      4'd2:    c = 8'd4;
      4'd3:    c = 8'd7;
      4'd4:    c = 8'd15;
      4'd5:    c = 8'd31;
      4'd6:    c = 8'd39;
      4'd7:    c = 8'd47;
      4'd8:    c = 8'd55;
      4'd9:    c = 8'd63;
      4'd10:   c = 8'd191;
      default: c = 8'd255;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/led_fire_heat_renderer.sv
// Channel   Dir  Payload     Handshake
// in_item   in   in_item_t   in_valid / in_stall
// out_item  out  out_item_t  out_valid / out_stall
//
// Decay: read then write of every column, through one address shared by both RAM ports.
// Inject with power p: read then write of each column touched, centre first, then right and left pairs.
// Render: heat is fetched first, then one pixel per cycle, HEIGHT pixels,
// slowed only by out_stall. Power 0 injects and unused actions are dropped while idle.
// Synchronous reset empties the heat store at once through per-column valid bits.
// Depends on lfhr_pkg, lfhr_ctrl, lfhr_dp, lfhr_ram.
module led_fire_heat_renderer
  import lfhr_pkg::*;
#(
  parameter int WIDTH  = 32,
  parameter int HEIGHT = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cmd_t    cmd;
  status_t status;

  lfhr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfhr_dp #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/lfhr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfhr_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lfhr_ctrl.sv
// Controller state machine for the fire heat renderer: sequences decay
// sweeps, inject rings and render rows. Depends on lfhr_pkg.
module lfhr_ctrl
  import lfhr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  status_t  status,
  output cmd_t     cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC_RD = 4'd1;
  localparam logic [3:0] S_DEC_WR = 4'd2;
  localparam logic [3:0] S_INR_RD = 4'd3;
  localparam logic [3:0] S_INR_WR = 4'd4;
  localparam logic [3:0] S_INL_RD = 4'd5;
  localparam logic [3:0] S_INL_WR = 4'd6;
  localparam logic [3:0] S_RND_RD = 4'd7;
  localparam logic [3:0] S_RND_LD = 4'd8;
  localparam logic [3:0] S_RND_EM = 4'd9;

  logic [3:0] state, state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.action)
            ACT_DECAY: begin
              cmd.load_dec = 1'b1;
              state_next   = S_DEC_RD;
            end
            ACT_INJECT: begin
              if (in_item.power != 5'd0) begin
                cmd.load_inj = 1'b1;
                state_next   = S_INR_RD;
              end
            end
            ACT_RENDER: begin
              cmd.load_rnd = 1'b1;
              state_next   = S_RND_RD;
            end
            default: ;
          endcase
        end
      end
      S_DEC_RD: state_next = S_DEC_WR;
      S_DEC_WR: begin
        cmd.wr_dec = 1'b1;
        if (status.ptr_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_DEC_RD;
        end
      end
      S_INR_RD: state_next = S_INR_WR;
      S_INR_WR: begin
        cmd.wr_inj = 1'b1;
        if (!status.d_zero) begin
          state_next = S_INL_RD;
        end else if (status.p_le2) begin
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_INR_RD;
        end
      end
      S_INL_RD: begin
        cmd.side   = 1'b1;
        state_next = S_INL_WR;
      end
      S_INL_WR: begin
        cmd.side   = 1'b1;
        cmd.wr_inj = 1'b1;
        if (status.p_le2) begin
          state_next = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_INR_RD;
        end
      end
      S_RND_RD: state_next = S_RND_LD;
      S_RND_LD: begin
        cmd.heat_ld = 1'b1;
        state_next  = S_RND_EM;
      end
      S_RND_EM: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.y_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/lfhr_dp.sv
// Datapath for the fire heat renderer: heat store with valid bits, ring
// pointers, saturating update, row counter and output register.
// Depends on lfhr_pkg and lfhr_ram.
module lfhr_dp
  import lfhr_pkg::*;
#(
  parameter int WIDTH  = 32,
  parameter int HEIGHT = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW   = $clog2(WIDTH);
  localparam int HW   = $clog2(HEIGHT + 1);
  localparam int YW   = $clog2(HEIGHT);
  localparam int MW   = (AW > 5) ? AW : 5;
  localparam int SUMW = ((HW > 5) ? HW : 5) + 1;
  localparam int SW   = HW + 1;

  logic [AW-1:0]  rptr, lptr, addr;
  logic [4:0]     pwr;
  logic           d_zero;
  logic [4:0]     col;
  logic [YW-1:0]  y;
  logic [HW-1:0]  heat;
  logic [WIDTH-1:0] valid;
  logic [HW-1:0]  rdata, cur, wdata;
  logic           we;
  logic [MW:0]    col_w, col_mod;
  logic [AW-1:0]  centre;
  logic [SUMW-1:0] sum;
  logic [SW-1:0]  s, t;
  logic [3:0]     idx;
  logic [YW+3:0]  y_ext;
  logic           out_free;

  assign col_w   = (MW+1)'(in_item.column);
  assign col_mod = (col_w >= (MW+1)'(WIDTH)) ? col_w - (MW+1)'(WIDTH) : col_w;
  assign centre  = col_mod[AW-1:0];

  assign addr = cmd.side ? lptr : rptr;
  assign cur  = valid[addr] ? rdata : '0;

  assign sum = SUMW'(cur) + SUMW'(pwr);
  always_comb begin
    if (cmd.wr_dec) begin
      wdata = (cur == '0) ? '0 : cur - HW'(1);
    end else if (sum >= SUMW'(HEIGHT)) begin
      wdata = HW'(HEIGHT);
    end else begin
      wdata = sum[HW-1:0];
    end
  end
  assign we = cmd.wr_dec || cmd.wr_inj;

  lfhr_ram #(.DW(HW), .DEPTH(WIDTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_dec) begin
      rptr <= '0;
    end else if (cmd.load_inj || cmd.load_rnd) begin
      rptr <= centre;
    end else if (cmd.step) begin
      rptr <= (rptr == AW'(WIDTH - 1)) ? '0 : rptr + AW'(1);
    end
    if (cmd.load_inj) begin
      lptr   <= centre;
      pwr    <= in_item.power;
      d_zero <= 1'b1;
    end else if (cmd.step) begin
      lptr   <= (lptr == '0) ? AW'(WIDTH - 1) : lptr - AW'(1);
      pwr    <= pwr - 5'd2;
      d_zero <= 1'b0;
    end
    if (cmd.load_rnd) begin
      col <= in_item.column;
      y   <= '0;
    end else if (cmd.emit) begin
      y <= y + YW'(1);
    end
    if (cmd.heat_ld) begin
      heat <= cur;
    end
  end

  assign s   = SW'(y) + SW'(heat);
  assign t   = s - SW'(HEIGHT);
  assign idx = (s < SW'(HEIGHT)) ? 4'd0 :
               (t >= SW'(FIRE_LEN - 1)) ? 4'(FIRE_LEN - 1) : t[3:0];
  assign y_ext = {4'b0, y};

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.pixel_row    <= y_ext[3:0];
      out_item.pixel_column <= col;
      out_item.colour       <= fire_colour(idx);
      out_item.last         <= (y == YW'(HEIGHT - 1));
    end
  end

  assign status.p_le2    = (pwr <= 5'd2);
  assign status.d_zero   = d_zero;
  assign status.ptr_last = (rptr == AW'(WIDTH - 1));
  assign status.y_last   = (y == YW'(HEIGHT - 1));
  assign status.out_free = out_free;

endmodule

FILE: verif/led_fire_heat_renderer_tb.sv
// Self-checking testbench for led_fire_heat_renderer: directed and episodic random
// decay/inject/render transactions, with per-pixel checks against a heat-map predictor.
// Depends on lfhr_pkg and the led_fire_heat_renderer RTL.
module led_fire_heat_renderer_tb
  import lfhr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 32;
  localparam int ROWS = 16;
  localparam int SHADES = 12;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [SHADES*8-1:0] FIRE_SHADES = {
    8'd255, 8'd191, 8'd63, 8'd55, 8'd47, 8'd39,
    8'd31, 8'd15, 8'd7, 8'd4, 8'd2, 8'd0
  };
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  led_fire_heat_renderer #(.WIDTH(COLS), .HEIGHT(ROWS)) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  in_item_t   pending_items[$];
  out_item_t  pixel_queue[$];
  logic [4:0] heat_model [COLS];
  out_item_t  want;

  int n_queued = 0;
  int n_offered = 0;
  int n_in_accepted = 0;
  int n_renders = 0;
  int n_pixels_checked = 0;
  int n_fail = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_left = 0;
  bit holdoff_req = 1'b0;
  bit holdoff_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic add_heat(input int col, input int amount);
    int v;
    v = int'(heat_model[col % COLS]) + amount;
    if (v >= ROWS) v = ROWS;
    heat_model[col % COLS] = 5'(v);
  endtask

  task automatic predict_pixels(input in_item_t it);
    int p;
    int d;
    int lvl;
    int idx;
    out_item_t px;
    case (it.action)
      ACT_DECAY: begin
        for (int i = 0; i < COLS; i++)
          if (heat_model[i] != 5'd0) heat_model[i] = heat_model[i] - 5'd1;
      end
      ACT_INJECT: begin
        p = int'(it.power);
        d = 0;
        while (p > 0) begin
          add_heat(int'(it.column) + d, p);
          if (d != 0) add_heat(int'(it.column) + COLS - (d % COLS), p);
          p -= 2;
          d++;
        end
      end
      ACT_RENDER: begin
        lvl = int'(heat_model[int'(it.column) % COLS]);
        for (int y = 0; y < ROWS; y++) begin
          idx = y + lvl - ROWS;
          if (idx < 0) idx = 0;
          if (idx > SHADES - 1) idx = SHADES - 1;
          px.pixel_row = 4'(y);
          px.pixel_column = it.column;
          px.colour = FIRE_SHADES[idx*8 +: 8];
          px.last = (y == ROWS - 1);
          pixel_queue.push_back(px);
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [1:0] act, input logic [4:0] col, input logic [4:0] pwr);
    in_item_t it;
    it.action = act;
    it.column = col;
    it.power = pwr;
    pending_items.push_back(it);
    n_queued++;
  endtask

  function automatic logic [4:0] rand_power();
    if ($urandom_range(99) < 85) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  // Episodes: injects near a centre, a little decay, renders around it or a dropped item.
  task automatic queue_fire_episodes(input int count);
    int target;
    int centre;
    target = n_queued + count;
    while (n_queued < target) begin
      centre = int'($urandom_range(0, COLS - 1));
      if ($urandom_range(99) < 10) begin
        if ($urandom_range(1) == 0)
          push_item(ACT_UNUSED, 5'($urandom), 5'($urandom));
        else
          push_item(ACT_INJECT, 5'(centre), 5'd0);
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(ACT_INJECT, 5'((centre + int'($urandom_range(0, 4)) + COLS - 2) % COLS),
                    rand_power());
        repeat ($urandom_range(0, 2))
          push_item(ACT_DECAY, 5'($urandom), 5'($urandom));
        repeat ($urandom_range(1, 3))
          push_item(ACT_RENDER, 5'((centre + int'($urandom_range(0, 16)) + COLS - 8) % COLS),
                    5'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || n_offered != n_in_accepted || pixel_queue.size() != 0)
      @(posedge clk);
  endtask

  // Sender: a new transaction is only offered once the previous one was taken.
  always @(negedge clk) begin
    if (!rst && n_offered == n_in_accepted) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        n_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off on request.
  always @(negedge clk) begin
    if (holdoff_req && !holdoff_done) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_done = 1'b1;
    end
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected pixel transaction: row %0d column %0d colour %0d last %0d",
                 out_item.pixel_row, out_item.pixel_column, out_item.colour, out_item.last);
          n_fail++;
        end else begin
          want = pixel_queue.pop_front();
          if (out_item.pixel_row !== want.pixel_row) begin
            $error("pixel_row: expected %0d, actual %0d", want.pixel_row, out_item.pixel_row);
            n_fail++;
          end
          if (out_item.pixel_column !== want.pixel_column) begin
            $error("pixel_column: expected %0d, actual %0d",
                   want.pixel_column, out_item.pixel_column);
            n_fail++;
          end
          if (out_item.colour !== want.colour) begin
            $error("colour: expected %0d, actual %0d", want.colour, out_item.colour);
            n_fail++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_item.last);
            n_fail++;
          end
          n_pixels_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_pixels(in_item);
        if (in_item.action == ACT_RENDER) n_renders++;
        n_in_accepted++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int i = 0; i < COLS; i++) heat_model[i] = 5'd0;
    send_idle_pct = 15;
    recv_idle_pct = 72;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: cold render, ignored codes, zero and oversized power, ring wrap
    push_item(ACT_RENDER, 5'd0, 5'd0);
    push_item(ACT_UNUSED, 5'd31, 5'd31);
    push_item(ACT_INJECT, 5'd5, 5'd0);
    push_item(ACT_RENDER, 5'd5, 5'd31);
    push_item(ACT_INJECT, 5'd0, 5'd31);
    push_item(ACT_RENDER, 5'd0, 5'd0);
    push_item(ACT_RENDER, 5'd31, 5'd0);
    push_item(ACT_RENDER, 5'd17, 5'd0);
    push_item(ACT_RENDER, 5'd16, 5'd0);
    push_item(ACT_INJECT, 5'd31, 5'd16);
    push_item(ACT_INJECT, 5'd31, 5'd1);
    push_item(ACT_RENDER, 5'd31, 5'd0);
    push_item(ACT_RENDER, 5'd1, 5'd0);
    push_item(ACT_DECAY, 5'd31, 5'd31);
    push_item(ACT_RENDER, 5'd0, 5'd0);
    push_item(ACT_INJECT, 5'd10, 5'd2);
    push_item(ACT_RENDER, 5'd10, 5'd0);
    push_item(ACT_INJECT, 5'd20, 5'd3);
    push_item(ACT_RENDER, 5'd19, 5'd0);
    push_item(ACT_DECAY, 5'd0, 5'd0);
    push_item(ACT_RENDER, 5'd21, 5'd0);
    push_item(ACT_INJECT, 5'd12, 5'd16);
    push_item(ACT_RENDER, 5'd12, 5'd0);
    wait_drained();

    queue_fire_episodes(115);
    wait_drained();

    send_idle_pct = 72;
    recv_idle_pct = 15;
    queue_fire_episodes(115);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_fire_episodes(110);
    holdoff_req = 1'b1;
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_queue.size() != 0)
      $error("%0d pixel transactions never arrived", pixel_queue.size());
    $display("Run covered %0d input transactions, %0d of them renders, over three stall mixes.",
             n_in_accepted, n_renders);
    $display("Checked %0d pixel transactions field by field; %0d mismatches.",
             n_pixels_checked, n_fail);
    if (n_fail == 0 && pixel_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lfhr_pkg.sv
rtl/lfhr_ram.sv
rtl/lfhr_ctrl.sv
rtl/lfhr_dp.sv
rtl/led_fire_heat_renderer.sv
verif/led_fire_heat_renderer_tb.sv
